// ----- rtl/ps2mc_pkg.sv -----
// Shared types and constants for the PS/2 mouse packet cursor block.
// Used by ps2mc_packet, ps2mc_cursor and ps2_mouse_packet_cursor.
package ps2mc_pkg;

    localparam int unsigned COORD_W = 12;
    localparam int unsigned DELTA_W = 9;

    // Header byte bit positions
    localparam int unsigned SYNC_BIT   = 3;
    localparam int unsigned X_SIGN_BIT = 4;
    localparam int unsigned Y_SIGN_BIT = 5;
    localparam int unsigned Y_OVF_BIT  = 7;
    localparam int unsigned X_OVF_BIT  = 6;

    localparam logic [COORD_W-1:0] X_LIMIT_RST = 12'd1023;
    localparam logic [COORD_W-1:0] Y_LIMIT_RST = 12'd767;

    typedef enum logic [0:0] {
        CFG_X_LIMIT = 1'b0,
        CFG_Y_LIMIT = 1'b1
    } t_cfg_idx;

    // Packet event handed from the byte sequencer to the cursor unit
    typedef struct packed {
        logic                       applied;
        logic                       dropped;
        logic signed [DELTA_W-1:0]  dx;
        logic signed [DELTA_W-1:0]  dy;
    } t_pkt_evt;

endpackage

// ----- rtl/ps2mc_packet.sv -----
// Byte sequencer: finds the header, collects the delta bytes, flags the packet.
// Depends on ps2mc_pkg.
module ps2mc_packet import ps2mc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_rx_byte,
    output t_pkt_evt   o_evt
);

    typedef enum logic [2:0] {
        ST_HDR = 3'b001,
        ST_XD  = 3'b010,
        ST_YD  = 3'b100
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_hdr, n_hdr;
    logic [7:0] r_xd, n_xd;

    always_comb begin
        n_phase       = r_phase;
        n_hdr         = r_hdr;
        n_xd          = r_xd;
        o_evt.applied = 1'b0;
        o_evt.dropped = 1'b0;
        o_evt.dx      = $signed({r_hdr[X_SIGN_BIT], r_xd});
        o_evt.dy      = $signed({r_hdr[Y_SIGN_BIT], i_rx_byte});
        unique case (r_phase)
            ST_HDR: begin
                // drop bytes without the sync bit
                if (i_rx_byte[SYNC_BIT]) begin
                    n_hdr   = i_rx_byte;
                    n_phase = ST_XD;
                end
            end
            ST_XD: begin
                n_xd    = i_rx_byte;
                n_phase = ST_YD;
            end
            ST_YD: begin
                n_phase = ST_HDR;
                if (r_hdr[Y_OVF_BIT] || r_hdr[X_OVF_BIT]) begin
                    o_evt.dropped = 1'b1;
                end else begin
                    o_evt.applied = 1'b1;
                end
            end
            default: begin
                n_phase = ST_HDR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ST_HDR;
            r_hdr   <= '0;
            r_xd    <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_hdr   <= n_hdr;
            r_xd    <= n_xd;
        end
    end

    a_ovf_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == ST_YD && (r_hdr[Y_OVF_BIT] || r_hdr[X_OVF_BIT]))
        |-> (o_evt.dropped && !o_evt.applied))
        else $error("overflow packet not dropped");

    a_flags_end_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (o_evt.applied || o_evt.dropped)) |=> (r_phase == ST_HDR))
        else $error("sequencer did not return to header after packet");

    a_hdr_synced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == ST_HDR && !i_rx_byte[SYNC_BIT]) |=> (r_phase == ST_HDR))
        else $error("byte without sync bit taken as header");

endmodule

// ----- rtl/ps2mc_cursor.sv -----
// Cursor position registers with clamped add of the packet deltas.
// Depends on ps2mc_pkg.
module ps2mc_cursor import ps2mc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  t_pkt_evt           i_evt,
    input  logic [COORD_W-1:0] i_x_limit,
    input  logic [COORD_W-1:0] i_y_limit,
    output logic [COORD_W-1:0] o_pos_x,
    output logic [COORD_W-1:0] o_pos_y
);

    logic [COORD_W-1:0] r_pos_x, r_pos_y;
    logic signed [COORD_W+1:0] sum_x, sum_y;
    logic [COORD_W-1:0] clamp_x, clamp_y;

    assign sum_x = $signed({2'b00, r_pos_x}) + (COORD_W+2)'(i_evt.dx);
    // screen y grows downward
    assign sum_y = $signed({2'b00, r_pos_y}) - (COORD_W+2)'(i_evt.dy);

    always_comb begin
        if (sum_x[COORD_W+1]) begin
            clamp_x = '0;
        end else if (sum_x[COORD_W:0] > {1'b0, i_x_limit}) begin
            clamp_x = i_x_limit;
        end else begin
            clamp_x = sum_x[COORD_W-1:0];
        end
        if (sum_y[COORD_W+1]) begin
            clamp_y = '0;
        end else if (sum_y[COORD_W:0] > {1'b0, i_y_limit}) begin
            clamp_y = i_y_limit;
        end else begin
            clamp_y = sum_y[COORD_W-1:0];
        end
    end

    assign o_pos_x = i_evt.applied ? clamp_x : r_pos_x;
    assign o_pos_y = i_evt.applied ? clamp_y : r_pos_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
        end else if (i_step) begin
            r_pos_x <= o_pos_x;
            r_pos_y <= o_pos_y;
        end
    end

    a_x_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_evt.applied) |=> (r_pos_x <= $past(i_x_limit)))
        else $error("cursor x above limit after packet");

    a_y_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_evt.applied) |=> (r_pos_y <= $past(i_y_limit)))
        else $error("cursor y above limit after packet");

    a_hold_unapplied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_evt.applied) |=> ($stable(r_pos_x) && $stable(r_pos_y)))
        else $error("cursor moved without an applied packet");

endmodule

// ----- rtl/ps2_mouse_packet_cursor.sv -----
// Top level of the PS/2 mouse packet cursor: input register, limit registers,
// result register. Depends on ps2mc_pkg, ps2mc_packet and ps2mc_cursor.

// Takes one mouse byte per cycle unless stalled and returns one result per byte: the
// cursor position after that byte plus applied/dropped flags for a completed packet.
// Each byte passes the byte register, then the result register; the sustained
// rate is one byte per clock while i_stall is low, set by the clamped cursor add.
// The byte register doubles as a skid stage, so one more byte is taken while a
// result is stalled. Limit writes are always ready and take effect on the next
// applied packet; write them only with no byte in flight.
module ps2_mouse_packet_cursor import ps2mc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_rx_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [COORD_W-1:0] o_cursor_x,
    output logic [COORD_W-1:0] o_cursor_y,
    output logic               o_packet_applied,
    output logic               o_packet_dropped,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  t_cfg_idx           i_cfg_index,
    input  logic [COORD_W-1:0] i_cfg_data
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_out_valid;
    logic [COORD_W-1:0] r_x_limit, r_y_limit;
    logic [COORD_W-1:0] r_cursor_x, r_cursor_y;
    logic               r_applied, r_dropped;
    logic               advance, step;
    t_pkt_evt           evt;
    logic [COORD_W-1:0] pos_x, pos_y;

    assign advance     = !r_out_valid || !i_stall;
    assign step        = r_in_valid && advance;
    assign o_stall     = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_limit <= X_LIMIT_RST;
            r_y_limit <= Y_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_X_LIMIT: r_x_limit <= i_cfg_data;
                CFG_Y_LIMIT: r_y_limit <= i_cfg_data;
            endcase
        end
    end

    // byte register: load whenever it is empty or moving forward
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    ps2mc_packet u_packet (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_rx_byte (r_in_byte),
        .o_evt     (evt)
    );

    ps2mc_cursor u_cursor (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_evt     (evt),
        .i_x_limit (r_x_limit),
        .i_y_limit (r_y_limit),
        .o_pos_x   (pos_x),
        .o_pos_y   (pos_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_cursor_x <= pos_x;
            r_cursor_y <= pos_y;
            r_applied  <= evt.applied;
            r_dropped  <= evt.dropped;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_cursor_x       = r_cursor_x;
    assign o_cursor_y       = r_cursor_y;
    assign o_packet_applied = r_applied;
    assign o_packet_dropped = r_dropped;

    a_step_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("processed byte produced no result");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled with room in the pipeline");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_applied && r_dropped))
        else $error("packet both applied and dropped");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for ps2_mouse_packet_cursor: drives mouse bytes and
// limit writes with random idling on both sides and checks every result.
// Depends on ps2mc_pkg and the block's RTL.
module tb_top;
    import ps2mc_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_X      = 2'd1,
        PH_Y      = 2'd2
    } t_pkt_phase;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               applied;
        logic               dropped;
    } t_cursor_res;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic [7:0]         i_rx_byte   = '0;
    logic               i_stall     = 1'b0;
    logic               i_cfg_valid = 1'b0;
    t_cfg_idx           i_cfg_index = CFG_X_LIMIT;
    logic [COORD_W-1:0] i_cfg_data  = '0;

    logic               o_stall;
    logic               o_valid;
    logic [COORD_W-1:0] o_cursor_x;
    logic [COORD_W-1:0] o_cursor_y;
    logic               o_packet_applied;
    logic               o_packet_dropped;
    logic               o_cfg_ready;

    // Mirror of the block's packet and cursor state
    t_pkt_phase         pkt_phase = PH_HEADER;
    logic [7:0]         hdr_byte  = '0;
    logic [7:0]         x_mag     = '0;
    logic [COORD_W-1:0] cur_x     = '0;
    logic [COORD_W-1:0] cur_y     = '0;
    logic [COORD_W-1:0] lim_x     = X_LIMIT_RST;
    logic [COORD_W-1:0] lim_y     = Y_LIMIT_RST;

    t_cursor_res cursor_q[$];
    t_cursor_res want;
    int          fail_cnt   = 0;
    int          stall_left = 0;
    bit          calm       = 1'b0;

    ps2_mouse_packet_cursor i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_cursor_x       (o_cursor_x),
        .o_cursor_y       (o_cursor_y),
        .o_packet_applied (o_packet_applied),
        .o_packet_dropped (o_packet_dropped),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("ps2_mouse_packet_cursor test failed");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic int sext9(input logic [7:0] mag, input logic neg);
        return neg ? int'(mag) - 256 : int'(mag);
    endfunction

    function automatic logic [COORD_W-1:0] clamp_coord(input int sum,
                                                       input logic [COORD_W-1:0] lim);
        if (sum < 0) return '0;
        if (sum > int'(lim)) return lim;
        return sum[COORD_W-1:0];
    endfunction

    function automatic void track_byte(input logic [7:0] b);
        t_cursor_res r;
        r.applied = 1'b0;
        r.dropped = 1'b0;
        case (pkt_phase)
            PH_HEADER: begin
                // drop bytes without the sync bit while hunting for a header
                if (b[SYNC_BIT]) begin
                    hdr_byte  = b;
                    pkt_phase = PH_X;
                end
            end
            PH_X: begin
                x_mag     = b;
                pkt_phase = PH_Y;
            end
            PH_Y: begin
                pkt_phase = PH_HEADER;
                if (hdr_byte[X_OVF_BIT] || hdr_byte[Y_OVF_BIT]) begin
                    r.dropped = 1'b1;
                end else begin
                    // screen y grows downward, so subtract the y delta
                    cur_x = clamp_coord(int'(cur_x) + sext9(x_mag, hdr_byte[X_SIGN_BIT]),
                                        lim_x);
                    cur_y = clamp_coord(int'(cur_y) - sext9(b, hdr_byte[Y_SIGN_BIT]),
                                        lim_y);
                    r.applied = 1'b1;
                end
            end
            default: pkt_phase = PH_HEADER;
        endcase
        r.x = cur_x;
        r.y = cur_y;
        cursor_q.push_back(r);
    endfunction

    // Predict on each accepted byte or limit write, then check each result
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) track_byte(i_rx_byte);
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_X_LIMIT) lim_x = i_cfg_data;
            else lim_y = i_cfg_data;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (cursor_q.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected result: x=%0d y=%0d applied=%b dropped=%b",
                             o_cursor_x, o_cursor_y, o_packet_applied, o_packet_dropped);
            end else begin
                want = cursor_q.pop_front();
                if (o_cursor_x !== want.x || o_cursor_y !== want.y ||
                    o_packet_applied !== want.applied ||
                    o_packet_dropped !== want.dropped) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display({"mismatch: expected x=%0d y=%0d a=%b d=%b, ",
                                  "got x=%0d y=%0d a=%b d=%b"},
                                 want.x, want.y, want.applied, want.dropped,
                                 o_cursor_x, o_cursor_y, o_packet_applied,
                                 o_packet_dropped);
                end
            end
        end
    end

    // Result side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= idle_len();
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_packet(input logic [7:0] hdr, input logic [7:0] dx,
                               input logic [7:0] dy);
        send_byte(hdr);
        send_byte(dx);
        send_byte(dy);
    endtask

    // Hold off new bytes until every pending transaction has come back
    task automatic drain();
        int guard;
        i_valid <= 1'b0;
        guard = 0;
        @(posedge i_clk);
        while (cursor_q.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_limits(input logic [COORD_W-1:0] xl, input logic [COORD_W-1:0] yl);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_X_LIMIT;
        i_cfg_data  <= xl;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_Y_LIMIT;
        i_cfg_data  <= yl;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [COORD_W-1:0] pick_limit();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r < 4) return COORD_W'($urandom_range(1, 300));
        return COORD_W'($urandom_range(0, 4095));
    endfunction

    task automatic send_random_packet();
        logic [7:0] hdr;
        hdr = 8'($urandom_range(0, 255));
        hdr[SYNC_BIT] = 1'b1;
        // keep most packets free of overflow bits
        if ($urandom_range(0, 4) != 0) begin
            hdr[X_OVF_BIT] = 1'b0;
            hdr[Y_OVF_BIT] = 1'b0;
        end
        send_packet(hdr, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic test_directed();
        send_byte(8'h00);                    // no sync bit: ignored
        send_byte(8'hF7);                    // every bit but sync: ignored
        send_packet(8'h08, 8'hFF, 8'h00);    // largest positive x step
        send_packet(8'h08, 8'h64, 8'h80);    // upward move clamps y at zero
        send_packet(8'h28, 8'h00, 8'h00);    // most negative y delta moves down
        send_packet(8'h38, 8'h00, 8'h00);    // most negative x and y deltas
        send_packet(8'hC8, 8'h7F, 8'h7F);    // both overflow bits: dropped
        send_packet(8'h48, 8'h10, 8'h10);    // x overflow only
        send_packet(8'h88, 8'h10, 8'h10);    // y overflow only
        send_packet(8'h08, 8'h08, 8'hFF);    // sync bits inside a packet
    endtask

    task automatic test_limits();
        set_limits('0, '0);
        send_packet(8'h28, 8'hFF, 8'h00);
        send_packet(8'h18, 8'h00, 8'h7F);
        set_limits('1, '1);
        repeat (17) send_packet(8'h28, 8'hFF, 8'h00);
        // lower the limits under the cursor: position holds until a packet lands
        set_limits(12'd100, 12'd50);
        send_byte(8'h00);
        send_packet(8'h08, 8'h00, 8'h00);
        set_limits(X_LIMIT_RST, Y_LIMIT_RST);
    endtask

    task automatic test_random(input int n_bytes);
        int sent;
        int r;
        int next_cfg;
        sent = 0;
        next_cfg = 100;
        while (sent < n_bytes) begin
            if (sent >= next_cfg) begin
                set_limits(pick_limit(), pick_limit());
                next_cfg += 100;
            end
            r = $urandom_range(0, 9);
            if (r == 0) begin
                send_byte(8'($urandom_range(0, 255)));
                sent += 1;
            end else if (r == 1) begin
                // truncated packet: header and one delta only
                send_byte(8'($urandom_range(0, 255)) | 8'h08);
                send_byte(8'($urandom_range(0, 255)));
                sent += 2;
            end else begin
                send_random_packet();
                sent += 3;
            end
        end
    endtask

    task automatic test_back_to_back();
        drain();
        calm = 1'b1;
        repeat (20) send_random_packet();
        drain();
        calm = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_limits();
        test_random(250);
        test_back_to_back();
        drain();
        repeat (8) @(posedge i_clk);
        if (fail_cnt == 0 && cursor_q.size() == 0) begin
            $display("ps2_mouse_packet_cursor test passed");
        end else begin
            $display("ps2_mouse_packet_cursor test failed");
        end
        $finish;
    end

endmodule
